// ===== rtl/iis_pkg.sv =====
// ----------------------------------------------------------------------------
// Integral image stream package
// Field widths, register indexes and shared types of the integral image block.
// ----------------------------------------------------------------------------
package iis_pkg;

  localparam int PIXEL_W    = 8;
  localparam int SUM_W      = 28;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic first_row;
    logic row_end;
    logic frame_end;
  } raster_flags_t;

endpackage

// ===== rtl/iis_raster.sv =====
// ----------------------------------------------------------------------------
// Integral image raster position
// Column and row counters of the pixel stream with end-of-row and end-of-frame
// flags, checked against the clamped image width and height.
// ----------------------------------------------------------------------------
module iis_raster #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [iis_pkg::CFG_W-1:0]        width_cfg,
  input  logic [iis_pkg::CFG_W-1:0]        height_cfg,
  output logic [$clog2(MAX_WIDTH)-1:0]     col,
  output iis_pkg::raster_flags_t           flags
);
  import iis_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [WCW-1:0] width_eff;
  logic [HCW-1:0] height_eff;
  logic           last_col;
  logic           last_row;

  always_comb begin
    if (width_cfg == '0) begin
      width_eff = WCW'(1);
    end else if (WCW'(width_cfg) > WCW'(MAX_WIDTH)) begin
      width_eff = WCW'(MAX_WIDTH);
    end else begin
      width_eff = WCW'(width_cfg);
    end
    if (height_cfg == '0) begin
      height_eff = HCW'(1);
    end else if (HCW'(height_cfg) > HCW'(MAX_HEIGHT)) begin
      height_eff = HCW'(MAX_HEIGHT);
    end else begin
      height_eff = HCW'(height_cfg);
    end
  end

  assign last_col = (WCW'(col_r) + WCW'(1)) >= width_eff;
  assign last_row = (HCW'(row_r) + HCW'(1)) >= height_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col             = col_r;
  assign flags.first_row = (row_r == '0);
  assign flags.row_end   = last_col;
  assign flags.frame_end = last_col && last_row;

endmodule

// ===== rtl/integral_image_stream_top.sv =====
// ----------------------------------------------------------------------------
// Integral image stream top level
// Streaming summed-area table over 8-bit raster pixels with row and frame flags.
// ----------------------------------------------------------------------------
// The block accepts one pixel transaction per clock while in_stall is low and
// returns one summed-area transaction per pixel through the stage-one and
// output registers. The summed-area values of the previous row live in a
// memory of MAX_WIDTH entries with one read port and one write port, used once
// each per pixel; a bypass register covers a read of the column that is being
// written in the same cycle, which happens for one-pixel-wide images. The first
// row of a frame adds no upper term. Width and height are clamped to 1..MAX_WIDTH
// and 1..MAX_HEIGHT and should be written only while the block is idle.
module integral_image_stream_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [iis_pkg::PIXEL_W-1:0]     in_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iis_pkg::SUM_W-1:0]       out_area_sum,
  output logic                            out_row_end,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [iis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iis_pkg::CFG_W-1:0]       cfg_wdata
);
  import iis_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RSW = CW + PIXEL_W + 1;

  logic [CFG_W-1:0]  width_r;
  logic [CFG_W-1:0]  height_r;

  logic              in_accept;
  logic [CW-1:0]     col;
  raster_flags_t     flags;
  logic [RSW-1:0]    run_r, run_cur;

  logic              s1_valid_r, s1_valid_nxt;
  logic [CW-1:0]     s1_col_r;
  logic [RSW-1:0]    s1_run_r;
  raster_flags_t     s1_flags_r;
  logic              s1_move;
  logic [SUM_W-1:0]  s1_upper;
  logic [SUM_W-1:0]  s1_sum;

  logic [SUM_W-1:0]  mem [MAX_WIDTH];
  logic [SUM_W-1:0]  rdata_r;
  logic [SUM_W-1:0]  byp_r;
  logic              byp_sel_r;

  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_area_sum_r;
  logic              out_row_end_r;
  logic              out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  iis_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_accept),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .col        (col),
    .flags      (flags)
  );

  assign run_cur = run_r + RSW'(in_pixel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (in_accept) begin
      run_r <= flags.row_end ? '0 : run_cur;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r   <= col;
      s1_run_r   <= run_cur;
      s1_flags_r <= flags;
      byp_sel_r  <= s1_move && (s1_col_r == col);
      byp_r      <= s1_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata_r <= mem[col];
    end
    if (s1_move) begin
      mem[s1_col_r] <= s1_sum;
    end
  end

  always_comb begin
    if (s1_flags_r.first_row) begin
      s1_upper = '0;
    end else if (byp_sel_r) begin
      s1_upper = byp_r;
    end else begin
      s1_upper = rdata_r;
    end
  end

  assign s1_sum = SUM_W'(s1_run_r) + s1_upper;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_area_sum_r  <= s1_sum;
      out_row_end_r   <= s1_flags_r.row_end;
      out_frame_end_r <= s1_flags_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_area_sum  = out_area_sum_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule
